// ===== src/stable_sorted_priority_queue_macros.svh =====
// Assertion macros shared by the checker of the sorted priority queue.
// No dependencies; the includer supplies i_clk and i_rst_n in scope.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define SSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define SSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ssq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes and the
// controller/datapath interface structs. No dependencies.
package ssq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int RANK_W   = 8;
    localparam int STS_W    = 2;
    localparam int OCC_W    = 5;

    // request types
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_DEQ_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_ENQ_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request beat
        logic exec;      // update slots and load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_sts;

endpackage

// ===== src/ssq_datapath.sv =====
// Datapath of the sorted priority queue: request latch, row of sorted
// slots with per-slot rank compare, fill count and result register. Uses ssq_pkg.
module ssq_datapath
    import ssq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic                     i_req_type,
    input  logic signed [VAL_W-1:0]  i_item_value,
    input  logic [RANK_W-1:0]        i_item_rank,
    output logic [STS_W-1:0]         o_status,
    output logic signed [VAL_W-1:0]  o_removed_value,
    output logic [RANK_W-1:0]        o_removed_rank,
    output logic signed [VAL_W-1:0]  o_head_value,
    output logic [RANK_W-1:0]        o_head_rank,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic                     o_is_empty
);

    logic                    r_req_type;
    logic signed [VAL_W-1:0] r_item_value;
    logic [RANK_W-1:0]       r_item_rank;

    logic signed [VAL_W-1:0] r_val  [CAPACITY];
    logic [RANK_W-1:0]       r_rank [CAPACITY];
    logic [CNT_W-1:0]        r_count;

    logic signed [VAL_W-1:0] n_val  [CAPACITY];
    logic [RANK_W-1:0]       n_rank [CAPACITY];
    logic [CNT_W-1:0]        n_count;

    logic [CAPACITY-1:0]     ge;      // slot held and ranked at or above new item
    logic                    full;
    logic                    empty;
    logic                    do_enq;
    logic                    do_deq;

    logic [STS_W-1:0]        n_status;
    logic signed [VAL_W-1:0] n_removed_value;
    logic [RANK_W-1:0]       n_removed_rank;

    logic [STS_W-1:0]        r_status;
    logic signed [VAL_W-1:0] r_removed_value;
    logic [RANK_W-1:0]       r_removed_rank;
    logic signed [VAL_W-1:0] r_head_value;
    logic [RANK_W-1:0]       r_head_rank;
    logic [CNT_W-1:0]        r_occ;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);
    assign o_sts = '{full: full, empty: empty};

    assign do_enq = (r_req_type == REQ_ENQ) && !full;
    assign do_deq = (r_req_type == REQ_DEQ) && !empty;

    // ge is a prefix since slots stay sorted; new entry lands at its first zero
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CNT_W'(i) < r_count) && (r_rank[i] >= r_item_rank);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_val[i]  = r_val[i];
            n_rank[i] = r_rank[i];
            if (do_enq) begin
                if (!ge[i]) begin
                    if (i == 0) begin
                        n_val[i]  = r_item_value;
                        n_rank[i] = r_item_rank;
                    end else if (ge[(i == 0) ? 0 : i - 1]) begin
                        n_val[i]  = r_item_value;
                        n_rank[i] = r_item_rank;
                    end else begin
                        n_val[i]  = r_val[(i == 0) ? 0 : i - 1];
                        n_rank[i] = r_rank[(i == 0) ? 0 : i - 1];
                    end
                end
            end else if (do_deq) begin
                if (i < CAPACITY - 1) begin
                    n_val[i]  = r_val[(i < CAPACITY - 1) ? i + 1 : i];
                    n_rank[i] = r_rank[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        n_count         = r_count;
        n_status        = STS_OK;
        n_removed_value = '0;
        n_removed_rank  = '0;
        if (do_enq) begin
            n_count = r_count + 1'b1;
        end else if (do_deq) begin
            n_count         = r_count - 1'b1;
            n_removed_value = r_val[0];
            n_removed_rank  = r_rank[0];
        end else if (r_req_type == REQ_DEQ) begin
            n_status = STS_DEQ_EMPTY;
        end else begin
            n_status = STS_ENQ_FULL;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type   <= i_req_type;
            r_item_value <= i_item_value;
            r_item_rank  <= i_item_rank;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_val[i]  <= n_val[i];
                r_rank[i] <= n_rank[i];
            end
            r_status        <= n_status;
            r_removed_value <= n_removed_value;
            r_removed_rank  <= n_removed_rank;
            r_head_value    <= (n_count != '0) ? n_val[0] : '0;
            r_head_rank     <= (n_count != '0) ? n_rank[0] : '0;
            r_occ           <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed_value;
    assign o_removed_rank  = r_removed_rank;
    assign o_head_value    = r_head_value;
    assign o_head_rank     = r_head_rank;
    assign o_occupancy     = OCC_W'(r_occ);
    assign o_is_empty      = (r_occ == '0);

endmodule

// ===== src/ssq_ctrl.sv =====
// Controller of the sorted priority queue: request/response handshake
// and sequencing of the datapath. Uses ssq_pkg.
module ssq_ctrl
    import ssq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_stall,
    output logic    o_rsp_valid,
    input  logic    i_rsp_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   out_free;
    logic   blocked;

    assign out_free = !r_rsp_valid || !i_rsp_stall;
    // a request while full or empty still runs; status alone flags it
    assign blocked  = 1'b0 & (i_sts.full | i_sts.empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_rsp_valid   = r_rsp_valid && i_rsp_stall;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_req_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_req_stall = blocked;
                if (i_req_valid && !blocked) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

// ===== src/stable_sorted_priority_queue.sv =====
// Sorted priority queue of CAPACITY entries (ssq_pkg), highest rank at the
// head, equal ranks kept in arrival order. Each request beat is an enqueue
// or a dequeue and yields exactly one response beat with status, removed
// entry, new head, occupancy and empty flag. The request beat is latched,
// then all slots compare their rank against the new item in parallel and
// shift in place; no new request is taken until that update is done. The
// response sits in an output register, so the next request beat is taken
// while the previous response is still stalled; the update waits only
// until that register is free. A full queue rejects an enqueue with the
// full status; an empty queue answers a dequeue with the empty status and
// zero fields. No clearing pass: only the fill count is reset, and slots
// beyond it never reach an output.
module stable_sorted_priority_queue
    import ssq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_req_valid,
    output logic                     o_req_stall,
    input  logic                     i_req_type,
    input  logic signed [VAL_W-1:0]  i_item_value,
    input  logic [RANK_W-1:0]        i_item_rank,
    // response channel
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_stall,
    output logic [STS_W-1:0]         o_status,
    output logic signed [VAL_W-1:0]  o_removed_value,
    output logic [RANK_W-1:0]        o_removed_rank,
    output logic signed [VAL_W-1:0]  o_head_value,
    output logic [RANK_W-1:0]        o_head_rank,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic                     o_is_empty
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // handshake and sequencing
    ssq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // slots, count and response register
    ssq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_rank     (i_item_rank),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_removed_rank  (o_removed_rank),
        .o_head_value    (o_head_value),
        .o_head_rank     (o_head_rank),
        .o_occupancy     (o_occupancy),
        .o_is_empty      (o_is_empty)
    );

endmodule

// ===== src/ssq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
// Uses ssq_pkg and the assertion macros header.
`include "stable_sorted_priority_queue_macros.svh"

module ssq_checker
    import ssq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     o_req_stall,
    input  logic                     o_rsp_valid,
    input  logic                     i_rsp_stall,
    input  logic [STS_W-1:0]         o_status,
    input  logic signed [VAL_W-1:0]  o_removed_value,
    input  logic [RANK_W-1:0]        o_removed_rank,
    input  logic signed [VAL_W-1:0]  o_head_value,
    input  logic [RANK_W-1:0]        o_head_rank,
    input  logic [OCC_W-1:0]         o_occupancy,
    input  logic                     o_is_empty
);

    logic req_beat;
    logic rsp_hold;

    assign req_beat = i_req_valid && !o_req_stall;
    assign rsp_hold = o_rsp_valid && i_rsp_stall;

    `SSQ_ASSERT_NEXT(a_rsp_hold, rsp_hold, o_rsp_valid && $stable(o_status) && $stable(o_head_value), "response changed while stalled")
    `SSQ_ASSERT_NEXT(a_one_in_flight, req_beat, o_req_stall, "second request taken before update")
    `SSQ_ASSERT_NOW(a_empty_flag, o_rsp_valid, o_is_empty == (o_occupancy == '0), "empty flag disagrees with occupancy")
    `SSQ_ASSERT_NOW(a_empty_head, o_rsp_valid && o_is_empty, (o_head_value == '0) && (o_head_rank == '0), "head not zero on empty queue")
    `SSQ_ASSERT_NOW(a_reject_zero, o_rsp_valid && (o_status != STS_OK), (o_removed_value == '0) && (o_removed_rank == '0), "removed entry on rejected request")

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (.*);
